@@ rtl/mme_pkg.sv @@
// Shared types and constants of the matrix multiply engine.
`default_nettype none

package mme_pkg;

   // Field widths fixed by the request and result formats
   localparam int ELEMENT_W   = 16;  // signed Q8.8 element
   localparam int PROD_W      = 32;  // Q8.8 x Q8.8 product, Q16.16
   localparam int SUM_W       = 36;  // sum of up to eight products, Q16.16
   localparam int OP_W        = 2;
   localparam int CFG_W       = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int COORD_W     = 3;

   // Request operation codes
   localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS_B    = 2'd2;

   // Tag that travels with one product term through the MAC
   typedef struct packed {
      logic valid;
      logic first;  // first term of a dot product
      logic last;   // last term of a dot product
   } mac_ctl_type;

endpackage

`default_nettype wire

@@ rtl/matrix_multiply_engine.sv @@
// Top level of the matrix multiply engine: sequencer, operand loading, result register.
//
//   Port group | Direction | Handshake           | Carries
//   req_*      | in        | req_valid/req_stall | operation, element_value, load_end
//   rsp_*      | out       | rsp_valid/rsp_stall | product_value, out_row, out_col,
//              |           |                     | last_result
//   csr_*      | in        | csr_write           | csr_index, csr_data (size registers)
//
// Load requests can be accepted back to back while the engine is idle.
// A compute request walks every element of C: each element issues n terms
// into the one shared multiply-accumulate unit, then waits for memory read,
// multiply and accumulate before handing the sum to the result register.
// req_stall is high for the whole compute; rsp_stall holds the sequencer in
// its wait state. Reset is synchronous; operand memories are not cleared.
`default_nettype none

module matrix_multiply_engine #(
   parameter int MAX_DIM = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // configuration
   input  wire logic                                  csr_write,
   input  wire logic [mme_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [mme_pkg::CFG_W-1:0]             csr_data,
   // requests
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [mme_pkg::OP_W-1:0]              req_operation,
   input  wire logic signed [mme_pkg::ELEMENT_W-1:0]  req_element_value,
   input  wire logic                                  req_load_end,
   // results
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [mme_pkg::SUM_W-1:0]           rsp_product_value,
   output logic [mme_pkg::COORD_W-1:0]                rsp_out_row,
   output logic [mme_pkg::COORD_W-1:0]                rsp_out_col,
   output logic                                       rsp_last_result
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = $clog2(DEPTH);        // memory address
   localparam int PW    = $clog2(DEPTH + 1);    // load pointer, can reach DEPTH
   localparam int DW    = $clog2(MAX_DIM + 1);  // clamped dimension
   localparam int IW    = $clog2(MAX_DIM);      // row, column and term counters

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_WAIT = 3'b100
   } seq_state_type;

   // ---------------------------------------------------------------
   // Size registers, clamped to 1..MAX_DIM
   // ---------------------------------------------------------------
   logic [mme_pkg::CFG_W-1:0] rows_a_ff, inner_dim_ff, cols_b_ff;
   logic [DW-1:0]             m_dim, n_dim, o_dim;

   function automatic logic [DW-1:0] clamp_dim(input logic [mme_pkg::CFG_W-1:0] v);
      logic [DW-1:0] r;
      if (v == '0) begin
         r = DW'(1);
      end else if (v > mme_pkg::CFG_W'(MAX_DIM)) begin
         r = DW'(MAX_DIM);
      end else begin
         r = DW'(v);
      end
      return r;
   endfunction

   assign m_dim = clamp_dim(rows_a_ff);
   assign n_dim = clamp_dim(inner_dim_ff);
   assign o_dim = clamp_dim(cols_b_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= mme_pkg::CFG_W'(8);
         inner_dim_ff <= mme_pkg::CFG_W'(8);
         cols_b_ff    <= mme_pkg::CFG_W'(8);
      end else if (csr_write) begin
         case (csr_index)
            mme_pkg::CSR_ROWS_A:    rows_a_ff    <= csr_data;
            mme_pkg::CSR_INNER_DIM: inner_dim_ff <= csr_data;
            mme_pkg::CSR_COLS_B:    cols_b_ff    <= csr_data;
            default: ;  // unmapped index: drop the write
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Request acceptance and operand loading
   // ---------------------------------------------------------------
   seq_state_type state_ff, state_in;
   logic          req_accept;
   logic          load_a, load_b;
   logic          a_wr, b_wr;
   logic [PW-1:0] a_ptr_ff, a_ptr_in, b_ptr_ff, b_ptr_in;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign load_a     = req_accept && (req_operation == mme_pkg::OP_LOAD_A);
   assign load_b     = req_accept && (req_operation == mme_pkg::OP_LOAD_B);
   // drop writes once a pointer has run past the end of its store
   assign a_wr       = load_a && (a_ptr_ff < PW'(DEPTH));
   assign b_wr       = load_b && (b_ptr_ff < PW'(DEPTH));

   always_comb begin
      a_ptr_in = a_ptr_ff;
      b_ptr_in = b_ptr_ff;
      if (a_wr) begin
         a_ptr_in = a_ptr_ff + PW'(1);
      end
      if (load_a && req_load_end) begin
         a_ptr_in = '0;
      end
      if (b_wr) begin
         b_ptr_in = b_ptr_ff + PW'(1);
      end
      if (load_b && req_load_end) begin
         b_ptr_in = '0;
      end
   end

   // ---------------------------------------------------------------
   // Sequencer: walk i over rows, j over columns, k over terms
   // ---------------------------------------------------------------
   logic [IW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [AW-1:0] a_base_ff, a_base_in;  // i * n
   logic [AW-1:0] a_addr_ff, a_addr_in;  // i * n + k
   logic [AW-1:0] b_addr_ff, b_addr_in;  // k * o + j
   logic          k_last, j_last, i_last;
   logic          issue;
   logic          take;
   logic          out_free;
   logic          sum_ready;
   logic signed [mme_pkg::SUM_W-1:0] sum;

   mme_pkg::mac_ctl_type issue_ctl, rd_ctl_ff;

   assign k_last   = (DW'(k_ff) + DW'(1)) == n_dim;
   assign j_last   = (DW'(j_ff) + DW'(1)) == o_dim;
   assign i_last   = (DW'(i_ff) + DW'(1)) == m_dim;
   assign issue    = (state_ff == ST_RUN);
   assign out_free = !rsp_valid || !rsp_stall;
   assign take     = (state_ff == ST_WAIT) && sum_ready && out_free;

   assign issue_ctl.valid = issue;
   assign issue_ctl.first = (k_ff == '0);
   assign issue_ctl.last  = k_last;

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      a_base_in = a_base_ff;
      a_addr_in = a_addr_ff;
      b_addr_in = b_addr_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_operation == mme_pkg::OP_COMPUTE)) begin
               state_in  = ST_RUN;
               i_in      = '0;
               j_in      = '0;
               k_in      = '0;
               a_base_in = '0;
               a_addr_in = '0;
               b_addr_in = '0;
            end
         end
         ST_RUN: begin
            // issue one term per cycle; step down a column of B
            if (k_last) begin
               state_in = ST_WAIT;
            end else begin
               k_in      = k_ff + IW'(1);
               a_addr_in = a_addr_ff + AW'(1);
               b_addr_in = b_addr_ff + AW'(o_dim);
            end
         end
         ST_WAIT: begin
            // hold until the sum is done and the result register is free
            if (take) begin
               k_in = '0;
               if (j_last) begin
                  j_in      = '0;
                  b_addr_in = '0;
                  if (i_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     state_in  = ST_RUN;
                     i_in      = i_ff + IW'(1);
                     a_base_in = a_base_ff + AW'(n_dim);
                     a_addr_in = a_base_ff + AW'(n_dim);
                  end
               end else begin
                  state_in  = ST_RUN;
                  j_in      = j_ff + IW'(1);
                  a_addr_in = a_base_ff;
                  b_addr_in = AW'(j_ff) + AW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
      a_base_ff <= a_base_in;
      a_addr_ff <= a_addr_in;
      b_addr_ff <= b_addr_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         a_ptr_ff  <= '0;
         b_ptr_ff  <= '0;
         rd_ctl_ff <= '0;
      end else begin
         state_ff  <= state_in;
         a_ptr_ff  <= a_ptr_in;
         b_ptr_ff  <= b_ptr_in;
         rd_ctl_ff <= issue_ctl;  // align the tag with the registered read data
      end
   end

   // ---------------------------------------------------------------
   // Operand memories and the shared multiply-accumulate unit
   // ---------------------------------------------------------------
   logic signed [mme_pkg::ELEMENT_W-1:0] a_data, b_data;

   mme_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store_a (
      .clock   (clock),
      .wr_en   (a_wr),
      .wr_addr (a_ptr_ff[AW-1:0]),
      .wr_data (req_element_value),
      .rd_en   (issue),
      .rd_addr (a_addr_ff),
      .rd_data (a_data)
   );

   mme_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store_b (
      .clock   (clock),
      .wr_en   (b_wr),
      .wr_addr (b_ptr_ff[AW-1:0]),
      .wr_data (req_element_value),
      .rd_en   (issue),
      .rd_addr (b_addr_ff),
      .rd_data (b_data)
   );

   mme_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .a_data    (a_data),
      .b_data    (b_data),
      .ctl       (rd_ctl_ff),
      .take      (take),
      .sum       (sum),
      .sum_ready (sum_ready)
   );

   // ---------------------------------------------------------------
   // Result register: load on take, drop valid once the result is taken
   // ---------------------------------------------------------------
   logic                             rsp_valid_ff, rsp_valid_in;
   logic signed [mme_pkg::SUM_W-1:0] rsp_product_value_ff;
   logic [mme_pkg::COORD_W-1:0]      rsp_out_row_ff, rsp_out_col_ff;
   logic                             rsp_last_result_ff;

   always_comb begin
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_product_value_ff <= sum;
         rsp_out_row_ff       <= mme_pkg::COORD_W'(i_ff);
         rsp_out_col_ff       <= mme_pkg::COORD_W'(j_ff);
         rsp_last_result_ff   <= i_last && j_last;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_product_value = rsp_product_value_ff;
   assign rsp_out_row       = rsp_out_row_ff;
   assign rsp_out_col       = rsp_out_col_ff;
   assign rsp_last_result   = rsp_last_result_ff;

endmodule

`default_nettype wire

@@ rtl/mme_store.sv @@
// One-write, one-read operand memory with registered read data.
`default_nettype none

module mme_store #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire logic                               clock,
   input  wire logic                               wr_en,
   input  wire logic [AW-1:0]                      wr_addr,
   input  wire logic signed [mme_pkg::ELEMENT_W-1:0] wr_data,
   input  wire logic                               rd_en,
   input  wire logic [AW-1:0]                      rd_addr,
   output logic signed [mme_pkg::ELEMENT_W-1:0]    rd_data
);

   logic signed [mme_pkg::ELEMENT_W-1:0] mem_ff [DEPTH];
   logic signed [mme_pkg::ELEMENT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/mme_mac.sv @@
// Shared multiply-accumulate unit: registered multiply, then accumulate.
`default_nettype none

module mme_mac (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic signed [mme_pkg::ELEMENT_W-1:0] a_data,
   input  wire logic signed [mme_pkg::ELEMENT_W-1:0] b_data,
   input  wire mme_pkg::mac_ctl_type                 ctl,
   input  wire logic                                 take,
   output logic signed [mme_pkg::SUM_W-1:0]          sum,
   output logic                                      sum_ready
);

   localparam int EXT_W = mme_pkg::SUM_W - mme_pkg::PROD_W;

   logic signed [mme_pkg::PROD_W-1:0] prod_ff, prod_in;
   mme_pkg::mac_ctl_type              ctl_ff;
   logic signed [mme_pkg::SUM_W-1:0]  acc_ff, acc_in;
   logic signed [mme_pkg::SUM_W-1:0]  prod_ext;
   logic                              ready_ff, ready_in;

   assign prod_in  = mme_pkg::PROD_W'(a_data) * mme_pkg::PROD_W'(b_data);
   assign prod_ext = $signed({{EXT_W{prod_ff[mme_pkg::PROD_W-1]}}, prod_ff});

   always_comb begin
      acc_in   = acc_ff;
      ready_in = ready_ff;
      if (ctl_ff.valid) begin
         acc_in = ctl_ff.first ? prod_ext : acc_ff + prod_ext;
      end
      // hold the finished sum until the sequencer takes it
      if (ctl_ff.valid && ctl_ff.last) begin
         ready_in = 1'b1;
      end else if (take) begin
         ready_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (reset) begin
         ctl_ff   <= '0;
         ready_ff <= 1'b0;
      end else begin
         ctl_ff   <= ctl;
         ready_ff <= ready_in;
      end
   end

   assign sum       = acc_ff;
   assign sum_ready = ready_ff;

endmodule

`default_nettype wire

@@ sim/matrix_product_checker.sv @@
// Result predictor and checker for the matrix multiply engine.
module matrix_product_checker
   import mme_pkg::*;
#(
   parameter int MAX_DIM = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write,
   input  wire logic [CSR_INDEX_W-1:0]        csr_index,
   input  wire logic [CFG_W-1:0]              csr_data,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire logic [OP_W-1:0]               req_operation,
   input  wire logic signed [ELEMENT_W-1:0]   req_element_value,
   input  wire logic                          req_load_end,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic signed [SUM_W-1:0]       rsp_product_value,
   input  wire logic [COORD_W-1:0]            rsp_out_row,
   input  wire logic [COORD_W-1:0]            rsp_out_col,
   input  wire logic                          rsp_last_result,
   output int unsigned                        error_count,
   output int unsigned                        pending_count
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;

   typedef struct packed {
      logic signed [SUM_W-1:0] value;
      logic [COORD_W-1:0]      row;
      logic [COORD_W-1:0]      col;
      logic                    last;
   } element_type;

   // index 0 holds A, index 1 holds B
   logic signed [ELEMENT_W-1:0] operand_store [2][DEPTH];
   int unsigned                 load_ptr [2];
   logic [CFG_W-1:0]            rows_cfg;
   logic [CFG_W-1:0]            inner_cfg;
   logic [CFG_W-1:0]            cols_cfg;
   element_type                 expected_elements [$];

   function automatic int unsigned dim_of(logic [CFG_W-1:0] raw);
      if (raw == '0) return 1;
      if (raw > MAX_DIM) return MAX_DIM;
      return int'(raw);
   endfunction

   task automatic note_error(string msg);
      if (error_count < 10) $display("%s", msg);
      error_count++;
   endtask

   // Queue every element of C in row-major order.
   task automatic predict_product();
      int unsigned             m;
      int unsigned             n;
      int unsigned             o;
      logic signed [SUM_W-1:0] acc;
      logic signed [SUM_W-1:0] term;
      element_type             e;
      m = dim_of(rows_cfg);
      n = dim_of(inner_cfg);
      o = dim_of(cols_cfg);
      for (int unsigned i = 0; i < m; i++) begin
         for (int unsigned j = 0; j < o; j++) begin
            acc = '0;
            for (int unsigned k = 0; k < n; k++) begin
               term = SUM_W'(operand_store[0][i * n + k]) *
                      SUM_W'(operand_store[1][k * o + j]);
               acc  = acc + term;
            end
            e.value = acc;
            e.row   = COORD_W'(i);
            e.col   = COORD_W'(j);
            e.last  = (i == m - 1) && (j == o - 1);
            expected_elements.push_back(e);
         end
      end
   endtask

   always @(posedge clock) begin : check_edge
      element_type got;
      element_type want;
      int          sel;
      if (reset) begin
         load_ptr[0] = 0;
         load_ptr[1] = 0;
         rows_cfg    = 4'd8;
         inner_cfg   = 4'd8;
         cols_cfg    = 4'd8;
         expected_elements.delete();
         error_count = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_ROWS_A:    rows_cfg  = csr_data;
               CSR_INNER_DIM: inner_cfg = csr_data;
               CSR_COLS_B:    cols_cfg  = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got.value = rsp_product_value;
            got.row   = rsp_out_row;
            got.col   = rsp_out_col;
            got.last  = rsp_last_result;
            if (expected_elements.size() == 0) begin
               note_error($sformatf("unexpected result value=%0d row=%0d col=%0d last=%0b",
                                    got.value, got.row, got.col, got.last));
            end else begin
               want = expected_elements.pop_front();
               if (got.value !== want.value || got.row !== want.row ||
                   got.col !== want.col || got.last !== want.last) begin
                  note_error($sformatf({"mismatch: expected value=%0d row=%0d col=%0d ",
                                        "last=%0b, got value=%0d row=%0d col=%0d last=%0b"},
                                       want.value, want.row, want.col, want.last,
                                       got.value, got.row, got.col, got.last));
               end
            end
         end
         if (req_valid && !req_stall) begin
            case (req_operation)
               OP_LOAD_A, OP_LOAD_B: begin
                  sel = (req_operation == OP_LOAD_B) ? 1 : 0;
                  if (load_ptr[sel] < DEPTH) begin
                     operand_store[sel][load_ptr[sel]] = req_element_value;
                     load_ptr[sel]++;
                  end
                  if (req_load_end) load_ptr[sel] = 0;
               end
               OP_COMPUTE: predict_product();
               default: ;
            endcase
         end
      end
      pending_count = expected_elements.size();
   end

endmodule

@@ sim/tb.sv @@
// Testbench top: stimulus, handshake pacing and verdict for the matrix multiply engine.
module tb;
   import mme_pkg::*;

   localparam int MAX_DIM       = 8;
   localparam int DEPTH         = MAX_DIM * MAX_DIM;
   localparam int RANDOM_ITEMS  = 24;
   localparam int SETTLE_CYCLES = 8;     // time for trailing loads and the MAC pipe to finish
   localparam int STALL_LIMIT   = 3000;  // cycles with no handshake at all

   // codes the block must ignore
   localparam logic [OP_W-1:0]        OP_RESERVED = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED  = 2'd3;

   logic                         clock             = 1'b0;
   logic                         reset             = 1'b1;
   logic                         csr_write         = 1'b0;
   logic [CSR_INDEX_W-1:0]       csr_index         = '0;
   logic [CFG_W-1:0]             csr_data          = '0;
   logic                         req_valid         = 1'b0;
   logic                         req_stall;
   logic [OP_W-1:0]              req_operation     = '0;
   logic signed [ELEMENT_W-1:0]  req_element_value = '0;
   logic                         req_load_end      = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_stall         = 1'b0;
   logic signed [SUM_W-1:0]      rsp_product_value;
   logic [COORD_W-1:0]           rsp_out_row;
   logic [COORD_W-1:0]           rsp_out_col;
   logic                         rsp_last_result;

   int unsigned error_count;
   int unsigned pending_count;
   int unsigned items_sent   = 0;  // loads and computes accepted
   int unsigned quiet_cycles = 0;
   int unsigned send_quiet   = 0;
   int unsigned stall_quiet  = 0;
   int unsigned stall_hold   = 0;
   // load pointers and written prefix of each store, index 0 for A, 1 for B
   int unsigned load_ptr [2] = '{0, 0};
   int unsigned written  [2] = '{0, 0};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   matrix_multiply_engine #(.MAX_DIM(MAX_DIM)) u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_element_value (req_element_value),
      .req_load_end      (req_load_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_product_value (rsp_product_value),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_last_result   (rsp_last_result)
   );

   matrix_product_checker #(.MAX_DIM(MAX_DIM)) u_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_element_value (req_element_value),
      .req_load_end      (req_load_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_product_value (rsp_product_value),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_last_result   (rsp_last_result),
      .error_count       (error_count),
      .pending_count     (pending_count)
   );

   // Mostly no gap, sometimes a short one, rarely a long one.
   function automatic int unsigned gap_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Random Q8.8 element, with the corner values mixed in.
   function automatic logic [ELEMENT_W-1:0] element_sample();
      case ($urandom_range(0, 11))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'h0000;
         3:       return 16'hffff;
         default: return ELEMENT_W'($urandom);
      endcase
   endfunction

   // Pick an effective size and a register value that encodes it; 0 stands
   // for 1 and anything above MAX_DIM stands for MAX_DIM.
   task automatic pick_size(output logic [CFG_W-1:0] raw, output int unsigned eff);
      if ($urandom_range(0, 9) < 7) eff = $urandom_range(1, 3);
      else eff = $urandom_range(4, MAX_DIM);
      raw = CFG_W'(eff);
      if (eff == 1 && $urandom_range(0, 2) == 0) raw = '0;
      if (eff == MAX_DIM && $urandom_range(0, 1) == 0) raw = CFG_W'($urandom_range(9, 15));
   endtask

   // Enter and leave at a falling edge with req_valid not yet assigned in that step.
   // Drop valid only when a gap follows, so back-to-back requests keep it high.
   task automatic send_request(input logic [OP_W-1:0] op,
                               input logic [ELEMENT_W-1:0] value,
                               input logic close);
      int unsigned gap;
      int          sel;
      if (send_quiet != 0) begin
         send_quiet--;
         gap = 0;
      end else begin
         gap = gap_length();
         if ($urandom_range(0, 24) == 0) send_quiet = $urandom_range(10, 40);
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_element_value <= value;
      req_load_end      <= close;
      // hold the request until the engine takes it
      do @(posedge clock); while (!(req_valid && !req_stall));
      if (op != OP_RESERVED) items_sent++;
      // track how far each store has been written
      if (op == OP_LOAD_A || op == OP_LOAD_B) begin
         sel = (op == OP_LOAD_B) ? 1 : 0;
         if (load_ptr[sel] < DEPTH) begin
            load_ptr[sel]++;
            if (load_ptr[sel] > written[sel]) written[sel] = load_ptr[sel];
         end
         if (close) load_ptr[sel] = 0;
      end
      @(negedge clock);
   endtask

   // Compute only when every entry it reads has been written; else send an ignored code.
   task automatic send_compute(input int unsigned m, input int unsigned n,
                               input int unsigned o);
      if (m * n <= written[0] && n * o <= written[1])
         send_request(OP_COMPUTE, element_sample(), 1'($urandom_range(0, 1)));
      else
         send_request(OP_RESERVED, element_sample(), 1'($urandom_range(0, 1)));
   endtask

   // Stream count elements into one operand store; close marks the final one.
   task automatic send_matrix(input logic [OP_W-1:0] op, input int unsigned count,
                              input logic close);
      for (int unsigned idx = 0; idx < count; idx++)
         send_request(op, element_sample(), close && (idx == count - 1));
   endtask

   // Write all size registers back to back, then release the write enable.
   task automatic write_sizes(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] inner,
                              input logic [CFG_W-1:0] cols, input bit touch_unused);
      csr_write <= 1'b1;
      csr_index <= CSR_ROWS_A;
      csr_data  <= rows;
      @(negedge clock);
      csr_index <= CSR_INNER_DIM;
      csr_data  <= inner;
      @(negedge clock);
      csr_index <= CSR_COLS_B;
      csr_data  <= cols;
      @(negedge clock);
      if (touch_unused) begin
         csr_index <= CSR_UNUSED;
         csr_data  <= CFG_W'($urandom);
         @(negedge clock);
      end
      csr_write <= 1'b0;
   endtask

   // Drain every outstanding result, then give trailing loads time to land.
   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Result-side back-pressure: random stalls with stall-free stretches.
   always @(negedge clock) begin
      if (stall_quiet != 0) begin
         stall_quiet--;
         rsp_stall <= 1'b0;
      end else if (stall_hold != 0) begin
         stall_hold--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 19) == 0) stall_quiet = $urandom_range(40, 150);
         else stall_hold = gap_length();
      end
   end

   // Watchdog: count cycles in which no channel moves anything.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin : stimulus
      logic [CFG_W-1:0] raw_m;
      logic [CFG_W-1:0] raw_n;
      logic [CFG_W-1:0] raw_o;
      logic [OP_W-1:0]  noise_op;
      int unsigned      m;
      int unsigned      n;
      int unsigned      o;
      int unsigned      start_items;
      int unsigned      kind;

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Scalar products on the operand corners; ignored codes and fields.
      write_sizes(4'd1, 4'd1, 4'd1, 1'b1);
      send_request(OP_LOAD_A, 16'h8000, 1'b1);
      send_request(OP_LOAD_B, 16'h8000, 1'b1);
      send_request(OP_COMPUTE, 16'h0000, 1'b0);
      send_request(OP_LOAD_A, 16'h7fff, 1'b1);
      send_request(OP_COMPUTE, 16'hffff, 1'b1);
      send_request(OP_LOAD_B, 16'h7fff, 1'b1);
      send_request(OP_COMPUTE, 16'h5a5a, 1'b0);
      send_request(OP_RESERVED, 16'hffff, 1'b1);
      send_request(OP_RESERVED, 16'h0000, 1'b0);
      send_request(OP_LOAD_A, 16'h0000, 1'b1);
      send_request(OP_COMPUTE, 16'hffff, 1'b1);

      // 2x1 times 1x2 with inner size written as zero; a compute between two
      // loads of A must leave the load pointer where it was.
      settle();
      write_sizes(4'd2, 4'd0, 4'd2, 1'b0);
      send_request(OP_LOAD_A, 16'h0100, 1'b0);
      send_request(OP_LOAD_A, 16'hff00, 1'b1);
      send_request(OP_LOAD_B, 16'h0080, 1'b0);
      send_request(OP_LOAD_B, 16'h8001, 1'b1);
      send_request(OP_COMPUTE, 16'h1234, 1'b0);
      send_request(OP_LOAD_A, 16'hc000, 1'b0);
      send_request(OP_COMPUTE, 16'h0000, 1'b1);
      send_request(OP_LOAD_A, 16'h4000, 1'b1);
      send_request(OP_COMPUTE, 16'hffff, 1'b0);

      // Widest result from single terms, columns written above the limit;
      // run the A pointer past the end of its store, then close it.
      settle();
      write_sizes(4'd8, 4'd1, 4'd15, 1'b0);
      send_matrix(OP_LOAD_B, MAX_DIM, 1'b1);
      send_matrix(OP_LOAD_A, DEPTH + $urandom_range(1, 3), 1'b1);
      send_request(OP_COMPUTE, element_sample(), 1'b1);

      // Random phases: new sizes each phase, mostly complete load-load-compute
      // sequences, plus truncated loads and loose noise.
      start_items = items_sent;
      while (items_sent - start_items < RANDOM_ITEMS) begin
         settle();
         pick_size(raw_m, m);
         pick_size(raw_n, n);
         pick_size(raw_o, o);
         write_sizes(raw_m, raw_n, raw_o, $urandom_range(0, 5) == 0);
         repeat ($urandom_range(1, 3)) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
               if ($urandom_range(0, 1) == 0) begin
                  send_matrix(OP_LOAD_A, m * n, 1'b1);
                  send_matrix(OP_LOAD_B, n * o, 1'b1);
               end else begin
                  send_matrix(OP_LOAD_B, n * o, 1'b1);
                  send_matrix(OP_LOAD_A, m * n, 1'b1);
               end
               send_compute(m, n, o);
            end else if (kind == 7) begin
               // cut short, possibly without closing the load
               send_matrix($urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A,
                           $urandom_range(1, m * n), 1'($urandom_range(0, 1)));
               send_compute(m, n, o);
            end else if (kind == 8) begin
               repeat ($urandom_range(1, 6)) begin
                  noise_op = OP_W'($urandom_range(0, 3));
                  if (noise_op == OP_COMPUTE)
                     send_compute(m, n, o);
                  else
                     send_request(noise_op, element_sample(), $urandom_range(0, 3) == 0);
               end
            end else begin
               send_compute(m, n, o);
            end
         end
      end

      settle();
      if (error_count == 0 && pending_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
